[rtl/psa_pkg.sv]
// shared types and constants for the pooled slot allocator
package psa_pkg;

    localparam int MaxPockets = 16;
    localparam int UnitsMax   = 64;
    localparam int SlotW      = 6;
    localparam int CountW     = 7;
    localparam int HandleW    = 10;
    localparam int StatusW    = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [StatusW-1:0] ST_OK      = 2'd0;
    localparam logic [StatusW-1:0] ST_NO_POCK = 2'd1;
    localparam logic [StatusW-1:0] ST_BAD     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

[rtl/psa_if.sv]
// valid/ready channel interfaces for requests and results
interface psa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [psa_pkg::HandleW-1:0]  handle_in;
    modport source (output valid, operation, handle_in, input ready);
    modport sink (input valid, operation, handle_in, output ready);
endinterface

interface psa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [psa_pkg::HandleW-1:0]  handle_out;
    logic [psa_pkg::StatusW-1:0]  status;
    modport source (output valid, handle_out, status, input ready);
    modport sink (input valid, handle_out, status, output ready);
endinterface

[rtl/psa_ctrl.sv]
// controller: sequences load, execute and result transfer
module psa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output psa_pkg::cmd_t    cmd
);

    psa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            psa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = psa_pkg::S_EXEC;
                end
            end
            psa_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = psa_pkg::S_OUT;
            end
            psa_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = psa_pkg::S_EXEC;
                    end
                    else
                        state_next = psa_pkg::S_IDLE;
                end
            end
            default: state_next = psa_pkg::S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("result not presented after execute");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("execute did not follow load");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and execute together");

endmodule

[rtl/psa_dp.sv]
// datapath: gap memory, pocket counters and result register
module psa_dp #(
    parameter int MAX_POCKETS = psa_pkg::MaxPockets,
    parameter int UNITS_MAX   = psa_pkg::UnitsMax
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psa_pkg::cmd_t                 cmd,
    input  logic                          cfg_we,
    input  logic [psa_pkg::CountW-1:0]    cfg_data,
    input  logic                          operation,
    input  logic [psa_pkg::HandleW-1:0]   handle_in,
    output logic [psa_pkg::HandleW-1:0]   handle_out,
    output logic [psa_pkg::StatusW-1:0]   status
);

    localparam int PW      = (MAX_POCKETS > 1) ? $clog2(MAX_POCKETS) : 1;
    localparam int LIM     = (UNITS_MAX < 64) ? UNITS_MAX : 64;
    localparam int DEPTH   = MAX_POCKETS * 64;
    localparam int AW      = PW + psa_pkg::SlotW;

    logic [psa_pkg::SlotW-1:0]  mem [DEPTH];
    logic [psa_pkg::SlotW-1:0]  head_reg  [MAX_POCKETS];
    logic [psa_pkg::CountW-1:0] count_reg [MAX_POCKETS];
    logic [psa_pkg::CountW-1:0] free_reg  [MAX_POCKETS];
    logic [psa_pkg::CountW-1:0] bump_reg;
    logic [PW-1:0]              cur_reg;
    logic [psa_pkg::CountW-1:0] units_reg;
    logic                       op_reg;
    logic [3:0]                 hpk_reg;
    logic [psa_pkg::SlotW-1:0]  hslot_reg;
    logic [psa_pkg::SlotW-1:0]  rd_reg;
    logic [PW-1:0]              at_reg;
    logic                       any_reg;
    logic [psa_pkg::HandleW-1:0] handle_reg;
    logic [psa_pkg::StatusW-1:0] status_reg;

    logic [psa_pkg::CountW-1:0] eff_units, eff_cfg;
    logic [PW-1:0]              at;
    logic                       any;
    logic [PW:0]                cur_inc;

    function automatic logic [psa_pkg::CountW-1:0] clamp_units(
        input logic [psa_pkg::CountW-1:0] u);
        logic [psa_pkg::CountW-1:0] r;
        r = u;
        if (r == '0) r = psa_pkg::CountW'(1);
        if (r > psa_pkg::CountW'(LIM)) r = psa_pkg::CountW'(LIM);
        return r;
    endfunction

    assign eff_units = clamp_units(units_reg);
    assign eff_cfg   = clamp_units(cfg_data);
    assign cur_inc   = {1'b0, cur_reg} + 1'b1;

    always_comb
    begin
        at  = '0;
        any = 1'b0;
        for (int p = MAX_POCKETS - 1; p >= 0; p--)
        begin
            if (count_reg[p] != '0)
            begin
                at  = PW'(p);
                any = 1'b1;
            end
        end
    end

    // load: latch request, lowest gap pocket and its fifo head entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            hpk_reg   <= handle_in[9:6];
            hslot_reg <= handle_in[5:0];
            at_reg    <= at;
            any_reg   <= any;
            rd_reg    <= mem[AW'({at, head_reg[at]})];
        end
    end

    logic                       tr_bad, do_open, no_pock;
    logic [PW-1:0]              pk;
    logic [psa_pkg::SlotW-1:0]  tail;

    always_comb
    begin
        pk      = PW'(hpk_reg);
        tr_bad  = ({1'b0, hpk_reg} > 5'(cur_reg)) || (32'(hpk_reg) >= MAX_POCKETS)
                  || ({1'b0, hslot_reg} >= eff_units);
        no_pock = (free_reg[cur_reg] == '0) && (32'(cur_inc) >= MAX_POCKETS);
        do_open = (free_reg[cur_reg] == '0) && !no_pock;
        tail    = head_reg[pk] + psa_pkg::SlotW'(count_reg[pk]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && op_reg == psa_pkg::OP_FREE && !tr_bad
            && count_reg[pk] < 7'd64 && free_reg[pk] < 7'd127)
            mem[AW'({pk, tail})] <= hslot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_POCKETS; p++)
            begin
                head_reg[p]  <= '0;
                count_reg[p] <= '0;
                free_reg[p]  <= (p == 0) ? psa_pkg::CountW'(LIM) : '0;
            end
            bump_reg   <= '0;
            cur_reg    <= '0;
            units_reg  <= 7'd64;
            handle_reg <= '0;
            status_reg <= psa_pkg::ST_OK;
        end
        else if (cfg_we)
        begin
            for (int p = 0; p < MAX_POCKETS; p++)
            begin
                head_reg[p]  <= '0;
                count_reg[p] <= '0;
                free_reg[p]  <= (p == 0) ? eff_cfg : '0;
            end
            bump_reg  <= '0;
            cur_reg   <= '0;
            units_reg <= cfg_data;
        end
        else if (cmd.exec)
        begin
            handle_reg <= '0;
            status_reg <= psa_pkg::ST_OK;
            if (op_reg == psa_pkg::OP_ALLOC)
            begin
                if (no_pock)
                    status_reg <= psa_pkg::ST_NO_POCK;
                else
                begin
                    logic [PW-1:0]              c;
                    logic [psa_pkg::CountW-1:0] f;
                    logic [psa_pkg::CountW-1:0] b;
                    c = do_open ? PW'(cur_inc) : cur_reg;
                    f = do_open ? eff_units : free_reg[c];
                    b = do_open ? '0 : bump_reg;
                    if (any_reg)
                    begin
                        head_reg[at_reg]  <= head_reg[at_reg] + 1'b1;
                        count_reg[at_reg] <= count_reg[at_reg] - 1'b1;
                        if (do_open)
                            free_reg[c] <= f;
                        if (at_reg == c)
                        begin
                            if (f != '0) free_reg[c] <= f - 1'b1;
                        end
                        else if (free_reg[at_reg] != '0)
                            free_reg[at_reg] <= free_reg[at_reg] - 1'b1;
                        handle_reg <= psa_pkg::HandleW'({at_reg, rd_reg});
                        bump_reg   <= b;
                    end
                    else
                    begin
                        free_reg[c] <= (f != '0) ? f - 1'b1 : f;
                        bump_reg    <= (b < 7'd127) ? b + 1'b1 : b;
                        handle_reg  <= psa_pkg::HandleW'({c, b[5:0]});
                    end
                    cur_reg <= c;
                end
            end
            else if (tr_bad)
                status_reg <= psa_pkg::ST_BAD;
            else if (count_reg[pk] < 7'd64 && free_reg[pk] < 7'd127)
            begin
                count_reg[pk] <= count_reg[pk] + 1'b1;
                free_reg[pk]  <= free_reg[pk] + 1'b1;
            end
        end
    end

    assign handle_out = handle_reg;
    assign status     = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && op_reg == psa_pkg::OP_FREE |=> handle_out == '0)
        else $error("free returned a handle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !cfg_we |=> cur_reg >= $past(cur_reg))
        else $error("current pocket went backward");
    assert property (@(posedge clk) disable iff (!rst_n)
        status != psa_pkg::ST_OK |-> handle_out == '0)
        else $error("error status with nonzero handle");

endmodule

[rtl/pooled_slot_allocator_top.sv]
// top level of the pooled slot allocator
// usage:
//   req channel carries operation (0 allocate, 1 free) and handle_in.
//   rsp channel returns handle_out and status for every request, in order.
//   a handle is pocket * 64 + slot.
//   cfg_we/cfg_data write units_per_pocket and restart the allocator; write
//   only while no request is in flight.
// timing:
//   the request transfer edge also latches the gap fifo head entry; the
//   execute state then updates the memory and counters and registers the
//   result, which is presented in the output state until it transfers.
//   a new request is taken in the same cycle as the result transfer, so a
//   request is not accepted while the previous result is still pending.
// reset:
//   pocket 0 is open with UNITS_MAX slots (at most 64), all gap fifos empty;
//   gap memory content is not cleared and its read data is only used once written.
// stall:
//   result holds while rsp.ready is low; no new request until it transfers.
module pooled_slot_allocator_top #(
    parameter int MAX_POCKETS = psa_pkg::MaxPockets,
    parameter int UNITS_MAX   = psa_pkg::UnitsMax
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [psa_pkg::CountW-1:0]  cfg_data,
    psa_req_if.sink                     req,
    psa_rsp_if.source                   rsp
);

    psa_pkg::cmd_t cmd;

    psa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    psa_dp #(
        .MAX_POCKETS (MAX_POCKETS),
        .UNITS_MAX   (UNITS_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .operation  (req.operation),
        .handle_in  (req.handle_in),
        .handle_out (rsp.handle_out),
        .status     (rsp.status)
    );

endmodule

[bench/testbench.sv]
// self-checking testbench for the pooled slot allocator
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic                          operation;
        logic [psa_pkg::HandleW-1:0]   handle;
    } request_t;

    typedef struct packed {
        logic [psa_pkg::HandleW-1:0]   handle;
        logic [psa_pkg::StatusW-1:0]   status;
    } outcome_t;

    typedef struct {
        logic                          operation;
        logic [psa_pkg::HandleW-1:0]   handle;
        logic                          known;
        logic [psa_pkg::HandleW-1:0]   want_handle;
        logic [psa_pkg::StatusW-1:0]   want_status;
    } vector_t;

    localparam int IdleLimit = 2000;
    localparam int RandomItems = 960;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [psa_pkg::CountW-1:0] cfg_data;
    psa_req_if req ();
    psa_rsp_if rsp ();

    pooled_slot_allocator_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    logic [psa_pkg::CountW-1:0] pocket_units;
    logic [psa_pkg::SlotW-1:0]  gap_slots [psa_pkg::MaxPockets*64];
    logic [psa_pkg::SlotW-1:0]  gap_rd    [psa_pkg::MaxPockets];
    logic [psa_pkg::CountW-1:0] gap_fill  [psa_pkg::MaxPockets];
    logic [psa_pkg::CountW-1:0] free_left [psa_pkg::MaxPockets];
    logic [psa_pkg::CountW-1:0] bump_used;
    logic [3:0]                 open_pocket;

    outcome_t expected_results [$];
    int failures;
    int idle_cycles;
    bit stall_on;
    int stall_mode;

    function automatic logic [psa_pkg::CountW-1:0] clamp_units(
        logic [psa_pkg::CountW-1:0] v);
        if (v == 0)
            return psa_pkg::CountW'(1);
        if (v > psa_pkg::UnitsMax)
            return psa_pkg::CountW'(psa_pkg::UnitsMax);
        return v;
    endfunction

    task automatic restart_pool(logic [psa_pkg::CountW-1:0] v);
        pocket_units = clamp_units(v);
        for (int p = 0; p < psa_pkg::MaxPockets; p++)
        begin
            gap_rd[p] = '0;
            gap_fill[p] = '0;
            free_left[p] = '0;
        end
        free_left[0] = pocket_units;
        bump_used = '0;
        open_pocket = '0;
    endtask

    function automatic outcome_t allocate_or_free(request_t r);
        outcome_t o;
        bit ok;
        int at;
        logic [3:0] pk;
        logic [psa_pkg::SlotW-1:0] slot;
        o = '0;
        if (r.operation == psa_pkg::OP_ALLOC)
        begin
            ok = 1;
            if (free_left[open_pocket] == 0)
            begin
                if (open_pocket + 1 >= psa_pkg::MaxPockets)
                begin
                    ok = 0;
                    o.status = psa_pkg::ST_NO_POCK;
                end
                else
                begin
                    open_pocket = open_pocket + 4'd1;
                    free_left[open_pocket] = pocket_units;
                    bump_used = '0;
                end
            end
            if (ok)
            begin
                at = -1;
                for (int p = psa_pkg::MaxPockets - 1; p >= 0; p--)
                    if (gap_fill[p] != 0)
                        at = p;
                if (at >= 0)
                begin
                    slot = gap_slots[at*64 + gap_rd[at]];
                    gap_rd[at] = gap_rd[at] + 1'b1;
                    gap_fill[at] = gap_fill[at] - 1'b1;
                    if (free_left[at] != 0)
                        free_left[at] = free_left[at] - 1'b1;
                    o.handle = {at[3:0], slot};
                end
                else
                begin
                    slot = bump_used[5:0];
                    if (bump_used < 127)
                        bump_used = bump_used + 1'b1;
                    if (free_left[open_pocket] != 0)
                        free_left[open_pocket] = free_left[open_pocket] - 1'b1;
                    o.handle = {open_pocket, slot};
                end
            end
        end
        else
        begin
            pk = r.handle[9:6];
            slot = r.handle[5:0];
            if (pk > open_pocket || slot >= pocket_units)
                o.status = psa_pkg::ST_BAD;
            else if (gap_fill[pk] < 64 && free_left[pk] < 127)
            begin
                gap_slots[pk*64 + 6'(gap_rd[pk] + gap_fill[pk])] = slot;
                gap_fill[pk] = gap_fill[pk] + 1'b1;
                free_left[pk] = free_left[pk] + 1'b1;
            end
        end
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result handle_out=%0d status=%0d",
                        rsp.handle_out, rsp.status);
                    failures++;
                end
                else
                begin
                    outcome_t e;
                    e = expected_results.pop_front();
                    if (rsp.handle_out !== e.handle)
                    begin
                        $error("handle_out expected %0d actual %0d", e.handle, rsp.handle_out);
                        failures++;
                    end
                    if (rsp.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, rsp.status);
                        failures++;
                    end
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= IdleLimit)
            begin
                $display("[pooled_slot_allocator_top] ERROR");
                $finish;
            end
        end
    end

    int burst_left;

    task automatic send_request(request_t r, bit known, outcome_t want);
        outcome_t predicted;
        while (burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        req.valid <= 1'b1;
        req.operation <= r.operation;
        req.handle_in <= r.handle;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        burst_left--;
        predicted = allocate_or_free(r);
        if (known && predicted != want)
        begin
            $error("predictor row mismatch handle expected %0d got %0d",
                want.handle, predicted.handle);
            failures++;
        end
        expected_results.insert(expected_results.size(), predicted);
    endtask

    task automatic drain;
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_units(logic [psa_pkg::CountW-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        restart_pool(v);
        @(posedge clk);
    endtask

    vector_t directed [] = '{
        '{psa_pkg::OP_ALLOC, 10'd0,    1, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_ALLOC, 10'h3ff,  1, 10'd1,   psa_pkg::ST_OK},
        '{psa_pkg::OP_FREE,  10'd0,    1, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_FREE,  10'd64,   1, 10'd0,   psa_pkg::ST_BAD},
        '{psa_pkg::OP_FREE,  10'h3ff,  1, 10'd0,   psa_pkg::ST_BAD},
        '{psa_pkg::OP_ALLOC, 10'd0,    1, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_FREE,  10'd1,    1, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_FREE,  10'd1,    1, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_ALLOC, 10'd0,    0, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_ALLOC, 10'd0,    0, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_FREE,  10'd63,   0, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_ALLOC, 10'h2aa,  0, 10'd0,   psa_pkg::ST_OK},
        '{psa_pkg::OP_FREE,  10'h155,  0, 10'd0,   psa_pkg::ST_OK}
    };

    logic [psa_pkg::CountW-1:0] unit_settings [] =
        '{7'd1, 7'd2, 7'd0, 7'd127, 7'd65, 7'd3, 7'd64, 7'd5};

    initial
    begin
        request_t r;
        outcome_t w;
        int held [$];
        int k;
        failures = 0;
        idle_cycles = 0;
        stall_mode = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.operation = psa_pkg::OP_ALLOC;
        req.handle_in = '0;
        rsp.ready = 1'b0;
        restart_pool(7'd64);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            r.operation = directed[i].operation;
            r.handle = directed[i].handle;
            w.handle = directed[i].want_handle;
            w.status = directed[i].want_status;
            send_request(r, directed[i].known, w);
        end

        // exhaust all pockets with a tiny pocket size, then overflow a gap fifo
        write_units(7'd1);
        for (int i = 0; i < 17; i++)
        begin
            r.operation = psa_pkg::OP_ALLOC;
            r.handle = '0;
            send_request(r, 0, '0);
        end
        for (int i = 0; i < 70; i++)
        begin
            r.operation = psa_pkg::OP_FREE;
            r.handle = 10'd0;
            send_request(r, 0, '0);
        end

        for (int s = 0; s < unit_settings.size(); s++)
        begin
            write_units(unit_settings[s]);
            held.delete();
            for (int i = 0; i < RandomItems / unit_settings.size(); i++)
            begin
                k = $urandom_range(0, 9);
                if (k < 5)
                begin
                    r.operation = psa_pkg::OP_ALLOC;
                    r.handle = 10'($urandom);
                end
                else if (k < 9 && held.size() != 0)
                begin
                    k = $urandom_range(0, held.size() - 1);
                    r.operation = psa_pkg::OP_FREE;
                    r.handle = held[k][psa_pkg::HandleW-1:0];
                    held.delete(k);
                end
                else
                begin
                    r.operation = psa_pkg::OP_FREE;
                    r.handle = 10'($urandom);
                end
                send_request(r, 0, '0);
                if (r.operation == psa_pkg::OP_ALLOC
                    && expected_results[$].status == psa_pkg::ST_OK)
                    held.insert(held.size(), int'(expected_results[$].handle));
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("[pooled_slot_allocator_top] OK");
        else
            $display("[pooled_slot_allocator_top] ERROR");
        $finish;
    end
endmodule
